FILE: sv/fbik_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the five-bar inverse kinematics block.
package fbik_pkg;

  localparam int CORDIC_W = 34;

  localparam logic signed [15:0] PI_Q      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q = 16'sd12868;
  localparam logic signed [17:0] PI_Q18    = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q  = 18'sd51472;

  typedef enum logic [2:0] {
    REG_LCRANK = 3'd0,
    REG_LROD   = 3'd1,
    REG_RROD   = 3'd2,
    REG_RCRANK = 3'd3,
    REG_BASE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [17:0] ex_l;
    logic signed [17:0] ex_r;
    logic signed [16:0] ey;
  } mid_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] motor;
    logic signed [15:0] joint;
  } side_res_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] left_motor_angle;
    logic signed [15:0] left_joint_angle;
    logic signed [15:0] right_joint_angle;
    logic signed [15:0] right_motor_angle;
  } out_item_t;

  function automatic logic signed [25:0] atan_step(input logic [4:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:    r = 26'sd13176795;
      5'd1:    r = 26'sd7778716;
      5'd2:    r = 26'sd4110060;
      5'd3:    r = 26'sd2086331;
      5'd4:    r = 26'sd1047214;
      5'd5:    r = 26'sd524117;
      5'd6:    r = 26'sd262123;
      5'd7:    r = 26'sd131069;
      default: r = 26'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PI_Q18) begin
      r = a - TWO_PI_Q;
    end else if (a <= -PI_Q18) begin
      r = a + TWO_PI_Q;
    end
    return r[15:0];
  endfunction

endpackage

FILE: sv/five_bar_inverse_kinematics_top.sv
`timescale 1ns / 1ps
// Five-bar linkage inverse kinematics: config registers, item queues and back-end control.
//
// Input channel: drive target_x_i/target_y_i and push; the item is taken on a clock edge
// with push high and full low. Items wait in a short queue until the solver is free.
// Result channel: while empty is low the oldest result is on the result ports; pop takes it.
// Configuration: APB-style writes to the five length registers at byte address 4*index;
// pready is always high, reads return the register value. Write only while the block is idle.
// Each side unit runs a 10-product multiply sequence, a 32-step square root and 24-step
// CORDIC atan2 units with shift normalization; both sides run in parallel and one item
// is solved at a time, so the next item starts only after the back-end control has
// returned to idle from the previous result entering the output queue. The input queue
// keeps accepting while the solver works, and finished results wait in the output queue,
// so a stalled receiver blocks the solver only once that queue is full.
// Reset: queues empty, solver idle, registers return to their default link lengths.
module five_bar_inverse_kinematics_top #(
  parameter int MidDepth = 2,
  parameter int OutDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  output logic               empty,
  input  logic               pop,
  output logic               valid_res_o,
  output logic signed [15:0] left_motor_angle_o,
  output logic signed [15:0] left_joint_angle_o,
  output logic signed [15:0] right_joint_angle_o,
  output logic signed [15:0] right_motor_angle_o
);
  import fbik_pkg::*;

  typedef enum logic {B_IDLE, B_RUN} back_state_e;

  logic [14:0] lcrank_q, lrod_q, rrod_q, rcrank_q, base_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  mid_item_t   front_item, mid_item;
  logic        mid_empty;
  out_item_t   out_in, out_item;
  logic        out_full, out_push;

  back_state_e back_q;
  logic        side_start, l_flag_q, r_flag_q, both_done;
  logic        l_busy, r_busy, l_done, r_done;
  side_res_t   l_res, r_res;
  logic        ok;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcrank_q <= 15'd3680;
      lrod_q   <= 15'd4320;
      rrod_q   <= 15'd4320;
      rcrank_q <= 15'd3680;
      base_q   <= 15'd3200;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LCRANK: lcrank_q <= pwdata[14:0];
        REG_LROD:   lrod_q   <= pwdata[14:0];
        REG_RROD:   rrod_q   <= pwdata[14:0];
        REG_RCRANK: rcrank_q <= pwdata[14:0];
        REG_BASE:   base_q   <= pwdata[14:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LCRANK: prdata = {17'd0, lcrank_q};
      REG_LROD:   prdata = {17'd0, lrod_q};
      REG_RROD:   prdata = {17'd0, rrod_q};
      REG_RCRANK: prdata = {17'd0, rcrank_q};
      REG_BASE:   prdata = {17'd0, base_q};
      default:    prdata = '0;
    endcase
  end

  fbik_front u_front (
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .base_len_i (base_q),
    .item_o     (front_item)
  );

  fbik_fifo #(
    .Width ($bits(mid_item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (side_start),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  assign side_start = (back_q == B_IDLE) && !mid_empty && !out_full && !l_busy && !r_busy;

  fbik_side u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (side_start),
    .pick_max_i  (1'b1),
    .ex_i        (mid_item.ex_l),
    .ey_i        (mid_item.ey),
    .crank_len_i (lcrank_q),
    .rod_len_i   (lrod_q),
    .busy_o      (l_busy),
    .done_o      (l_done),
    .res_o       (l_res)
  );

  fbik_side u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (side_start),
    .pick_max_i  (1'b0),
    .ex_i        (mid_item.ex_r),
    .ey_i        (mid_item.ey),
    .crank_len_i (rcrank_q),
    .rod_len_i   (rrod_q),
    .busy_o      (r_busy),
    .done_o      (r_done),
    .res_o       (r_res)
  );

  assign both_done = (l_flag_q || l_done) && (r_flag_q || r_done);
  assign out_push  = (back_q == B_RUN) && both_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q   <= B_IDLE;
      l_flag_q <= 1'b0;
      r_flag_q <= 1'b0;
    end else begin
      unique case (back_q)
        B_IDLE: begin
          if (side_start) begin
            back_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (both_done) begin
            l_flag_q <= 1'b0;
            r_flag_q <= 1'b0;
            back_q   <= B_IDLE;
          end else begin
            l_flag_q <= l_flag_q || l_done;
            r_flag_q <= r_flag_q || r_done;
          end
        end
        default: back_q <= B_IDLE;
      endcase
    end
  end

  assign ok = l_res.ok && r_res.ok;
  assign out_in.valid_res         = ok;
  assign out_in.left_motor_angle  = ok ? l_res.motor : 16'sd0;
  assign out_in.left_joint_angle  = ok ? l_res.joint : 16'sd0;
  assign out_in.right_joint_angle = ok ? r_res.joint : 16'sd0;
  assign out_in.right_motor_angle = ok ? r_res.motor : 16'sd0;

  fbik_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item),
    .empty_o (empty)
  );

  assign valid_res_o         = out_item.valid_res;
  assign left_motor_angle_o  = out_item.left_motor_angle;
  assign left_joint_angle_o  = out_item.left_joint_angle;
  assign right_joint_angle_o = out_item.right_joint_angle;
  assign right_motor_angle_o = out_item.right_motor_angle;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("result pushed into a full output queue");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !valid_res_o) |-> (left_motor_angle_o == 16'sd0 &&
      left_joint_angle_o == 16'sd0 && right_joint_angle_o == 16'sd0 &&
      right_motor_angle_o == 16'sd0))
    else $error("unreachable item carries nonzero angles");

  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (left_motor_angle_o > -PI_Q && left_motor_angle_o <= PI_Q &&
      right_motor_angle_o > -PI_Q && right_motor_angle_o <= PI_Q))
    else $error("motor angle outside wrap range");
`endif

endmodule

FILE: sv/fbik_fifo.sv
`timescale 1ns / 1ps
// Small register-based queue with push/full and pop/empty handshakes.
module fbik_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: sv/fbik_front.sv
`timescale 1ns / 1ps
// Front end: turns a target point into doubled offsets from both motor axes.
module fbik_front (
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic        [14:0] base_len_i,
  output fbik_pkg::mid_item_t item_o
);
  import fbik_pkg::*;

  logic signed [17:0] x2, base;

  assign x2   = $signed({target_x_i[15], target_x_i, 1'b0});
  assign base = $signed({3'b000, base_len_i});

  assign item_o.ex_l = x2 + base;
  assign item_o.ex_r = x2 - base;
  assign item_o.ey   = $signed({target_y_i, 1'b0});

endmodule

FILE: sv/fbik_cordic.sv
`timescale 1ns / 1ps
// Iterative vectoring CORDIC atan2 with shift normalization, Q3.13 radians out.
module fbik_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [fbik_pkg::CORDIC_W-1:0]   x_i,
  input  logic signed [fbik_pkg::CORDIC_W-1:0]   y_i,
  output logic                                   busy_o,
  output logic signed [15:0]                     angle_o
);
  import fbik_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_END} cordic_state_e;

  cordic_state_e         state_q;
  logic [CORDIC_W-1:0]   cx_q, cy_q, or_v;
  logic                  xneg_q, yneg_q;
  logic [4:0]            cnt_q;
  logic signed [25:0]    z_q, zc, zr, step;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic [14:0]           zq15;
  logic signed [15:0]    zq, a;

  assign busy_o = (state_q != C_IDLE);
  assign or_v   = cx_q | cy_q;
  assign dx     = $signed(cy_q) >>> cnt_q;
  assign dy     = $signed(cx_q) >>> cnt_q;
  assign step   = atan_step(cnt_q);
  assign zc     = z_q[25] ? 26'sd0 : z_q;
  assign zr     = zc + 26'sd1024;
  assign zq15   = zr[25:11];
  assign zq     = ($signed({1'b0, zq15}) > HALF_PI_Q) ? HALF_PI_Q : $signed({1'b0, zq15});
  assign a      = xneg_q ? PI_Q - zq : zq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      angle_o <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      z_q     <= '0;
      xneg_q  <= 1'b0;
      yneg_q  <= 1'b0;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            xneg_q <= x_i[CORDIC_W-1];
            yneg_q <= y_i[CORDIC_W-1];
            cx_q   <= x_i[CORDIC_W-1] ? CORDIC_W'(-x_i) : x_i;
            cy_q   <= y_i[CORDIC_W-1] ? CORDIC_W'(-y_i) : y_i;
            if (y_i == '0) begin
              angle_o <= x_i[CORDIC_W-1] ? PI_Q : 16'sd0;
            end else if (x_i == '0) begin
              angle_o <= y_i[CORDIC_W-1] ? -HALF_PI_Q : HALF_PI_Q;
            end else begin
              state_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (|or_v[CORDIC_W-1:30]) begin
            cx_q <= cx_q >> 1;
            cy_q <= cy_q >> 1;
          end else if (~|or_v[29:22]) begin
            cx_q <= cx_q << 8;
            cy_q <= cy_q << 8;
          end else if (!or_v[29]) begin
            cx_q <= cx_q << 1;
            cy_q <= cy_q << 1;
          end else begin
            cnt_q   <= '0;
            z_q     <= '0;
            state_q <= C_ITER;
          end
        end
        C_ITER: begin
          if ($signed(cy_q) > 0) begin
            cx_q <= $signed(cx_q) + dx;
            cy_q <= $signed(cy_q) - dy;
            z_q  <= z_q + step;
          end else begin
            cx_q <= $signed(cx_q) - dx;
            cy_q <= $signed(cy_q) + dy;
            z_q  <= z_q - step;
          end
          if (cnt_q == 5'd23) begin
            state_q <= C_END;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        C_END: begin
          angle_o <= (yneg_q && (a != PI_Q)) ? -a : a;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/fbik_side.sv
`timescale 1ns / 1ps
// Back-end solver for one side: circle intersection, square root and three atan2 units.
module fbik_side (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  pick_max_i,
  input  logic signed [17:0]    ex_i,
  input  logic signed [16:0]    ey_i,
  input  logic        [14:0]    crank_len_i,
  input  logic        [14:0]    rod_len_i,
  output logic                  busy_o,
  output logic                  done_o,
  output fbik_pkg::side_res_t   res_o
);
  import fbik_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_PRE, S_CHK, S_TEST, S_PP, S_SQI, S_SQRT, S_ANG, S_WAIT, S_FIN
  } side_state_e;

  side_state_e        state_q;
  logic [4:0]         cnt_q;
  logic signed [17:0] ex_q;
  logic signed [16:0] ey_q;
  logic [14:0]        rc_q, rr_q;
  logic [35:0]        mul_q;
  logic [17:0]        mul_a, mul_b;
  logic [35:0]        sq_q [6];
  logic [33:0]        q_q;
  logic signed [35:0] f1_q, f2_q, m_q, k_q;
  logic [67:0]        acc_q, pp_sh;
  logic [63:0]        n_q, rt_q, bit_v, trial;
  logic               ok_q, ge;
  logic [17:0]        abs_ex, abs_ey;
  logic [15:0]        sum_v;
  logic [14:0]        dif_v;
  logic [35:0]        c4, r4, s4, d4, qx;
  logic               beta_busy, alpha_busy, psi_busy, ang_start;
  logic signed [15:0] beta, alpha, psi, cm, cp;
  logic               use_p;
  logic signed [CORDIC_W-1:0] s_arg, bx, by;

  assign busy_o = (state_q != S_IDLE);
  assign abs_ex = ex_q[17] ? 18'(-ex_q) : ex_q;
  assign abs_ey = ey_q[16] ? 18'(-{ey_q[16], ey_q}) : {1'b0, ey_q};
  assign sum_v  = {1'b0, rc_q} + {1'b0, rr_q};
  assign dif_v  = (rc_q > rr_q) ? rc_q - rr_q : rr_q - rc_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      case (cnt_q[2:0])
        3'd0:    begin mul_a = abs_ex;           mul_b = abs_ex;           end
        3'd1:    begin mul_a = abs_ey;           mul_b = abs_ey;           end
        3'd2:    begin mul_a = {2'b00, sum_v};   mul_b = {2'b00, sum_v};   end
        3'd3:    begin mul_a = {3'b000, dif_v};  mul_b = {3'b000, dif_v};  end
        3'd4:    begin mul_a = {3'b000, rc_q};   mul_b = {3'b000, rc_q};   end
        3'd5:    begin mul_a = {3'b000, rr_q};   mul_b = {3'b000, rr_q};   end
        default: begin mul_a = '0;               mul_b = '0;               end
      endcase
    end else if (state_q == S_PP) begin
      case (cnt_q[2:0])
        3'd0:    begin mul_a = {1'b0, f1_q[16:0]};  mul_b = {1'b0, f2_q[16:0]};  end
        3'd1:    begin mul_a = {1'b0, f1_q[16:0]};  mul_b = {1'b0, f2_q[33:17]}; end
        3'd2:    begin mul_a = {1'b0, f1_q[33:17]}; mul_b = {1'b0, f2_q[16:0]};  end
        3'd3:    begin mul_a = {1'b0, f1_q[33:17]}; mul_b = {1'b0, f2_q[33:17]}; end
        default: begin mul_a = '0;                  mul_b = '0;                  end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_comb begin
    pp_sh = {32'd0, mul_q};
    case (cnt_q[2:0])
      3'd2, 3'd3: pp_sh = {32'd0, mul_q} << 17;
      3'd4:       pp_sh = {32'd0, mul_q} << 34;
      default:    pp_sh = {32'd0, mul_q};
    endcase
  end

  assign s4 = {sq_q[2][33:0], 2'b00};
  assign d4 = {sq_q[3][33:0], 2'b00};
  assign c4 = {sq_q[4][33:0], 2'b00};
  assign r4 = {sq_q[5][33:0], 2'b00};
  assign qx = {2'b00, q_q};

  assign bit_v = 64'd1 << (7'd62 - {1'b0, cnt_q, 1'b0});
  assign trial = rt_q + bit_v;
  assign ge    = (n_q >= trial);

  assign bx    = {{(CORDIC_W-18){ex_i[17]}}, ex_i};
  assign by    = {{(CORDIC_W-17){ey_i[16]}}, ey_i};
  assign s_arg = {2'b00, rt_q[31:0]};
  assign ang_start = (state_q == S_ANG);

  fbik_cordic u_beta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && (state_q == S_IDLE)),
    .x_i     (bx),
    .y_i     (by),
    .busy_o  (beta_busy),
    .angle_o (beta)
  );

  fbik_cordic u_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_start),
    .x_i     (m_q[35:2]),
    .y_i     (s_arg),
    .busy_o  (alpha_busy),
    .angle_o (alpha)
  );

  fbik_cordic u_psi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ang_start),
    .x_i     (k_q[35:2]),
    .y_i     (s_arg),
    .busy_o  (psi_busy),
    .angle_o (psi)
  );

  assign cm    = wrap_ang($signed({{2{beta[15]}}, beta}) - $signed({{2{alpha[15]}}, alpha}));
  assign cp    = wrap_ang($signed({{2{beta[15]}}, beta}) + $signed({{2{alpha[15]}}, alpha}));
  assign use_p = (f1_q != '0) && (f2_q != '0) && (pick_max_i ? (cp > cm) : (cp < cm));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_o  <= 1'b0;
      ok_q    <= 1'b0;
      res_o   <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            ex_q    <= ex_i;
            ey_q    <= ey_i;
            rc_q    <= crank_len_i;
            rr_q    <= rod_len_i;
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q != '0) begin
            sq_q[cnt_q[2:0] - 3'd1] <= mul_q;
          end
          if (cnt_q == 5'd6) begin
            state_q <= S_PRE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_PRE: begin
          q_q     <= sq_q[0][33:0] + sq_q[1][33:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          f1_q    <= $signed(s4) - $signed(qx);
          f2_q    <= $signed(qx) - $signed(d4);
          m_q     <= $signed(c4) - $signed(r4) + $signed(qx);
          k_q     <= $signed(c4) + $signed(r4) - $signed(qx);
          state_q <= S_TEST;
        end
        S_TEST: begin
          cnt_q <= '0;
          if ((q_q == '0) || f1_q[35] || f2_q[35]) begin
            ok_q    <= 1'b0;
            state_q <= S_WAIT;
          end else begin
            ok_q    <= 1'b1;
            state_q <= S_PP;
          end
        end
        S_PP: begin
          if (cnt_q == '0) begin
            acc_q <= '0;
          end else begin
            acc_q <= acc_q + pp_sh;
          end
          if (cnt_q == 5'd4) begin
            state_q <= S_SQI;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SQI: begin
          n_q     <= acc_q[67:4];
          rt_q    <= '0;
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          n_q  <= ge ? n_q - trial : n_q;
          rt_q <= ge ? (rt_q >> 1) + bit_v : rt_q >> 1;
          if (cnt_q == 5'd31) begin
            state_q <= S_ANG;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_ANG: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (!beta_busy && !alpha_busy && !psi_busy) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          res_o.ok    <= ok_q;
          res_o.motor <= use_p ? cp : cm;
          res_o.joint <= use_p
            ? wrap_ang($signed({{2{psi[15]}}, psi}) - PI_Q18)
            : wrap_ang(PI_Q18 - $signed({{2{psi[15]}}, psi}));
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the five-bar inverse kinematics block.
module testbench;
  import fbik_pkg::*;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] lm;
    logic signed [15:0] lj;
    logic signed [15:0] rj;
    logic signed [15:0] rm;
  } angles_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 known;
    angles_t            res;
  } target_row_t;

  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0, full, empty, pop = 1'b0;
  logic signed [15:0] target_x_i = '0, target_y_i = '0;
  logic        valid_res_o;
  logic signed [15:0] left_motor_angle_o, left_joint_angle_o;
  logic signed [15:0] right_joint_angle_o, right_motor_angle_o;

  five_bar_inverse_kinematics_top u_top (.*);

  longint lens [5];
  angles_t angle_q [$];
  int errors = 0;
  int n_solved = 0;
  int n_unreach = 0;
  longint cycles = 0;
  bit calm = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    if (v < 0) return -((-v + ((longint'(1) << s) - 1)) >>> s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint wrap_pi(longint a);
    while (a > 25736) a -= 51472;
    while (a <= -25736) a += 51472;
    return a;
  endfunction

  function automatic longint cordic_atan2(longint y, longint x);
    longint unsigned ax, ay;
    longint cx, cy, z = 0, zq, a, st, dx, dy;
    longint tab [8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                        262123, 131069};
    if (y == 0) return x < 0 ? 25736 : 0;
    if (x == 0) return y > 0 ? 12868 : -12868;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    while ((ax | ay) >= (64'd1 << 30)) begin
      ax >>= 1;
      ay >>= 1;
    end
    while ((ax | ay) < (64'd1 << 29)) begin
      ax <<= 1;
      ay <<= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < 24; i++) begin
      st = i < 8 ? tab[i] : (longint'(1) << (24 - i));
      dx = asr(cy, i);
      dy = asr(cx, i);
      if (cy > 0) begin
        cx += dx;
        cy -= dy;
        z += st;
      end else begin
        cx -= dx;
        cy += dy;
        z -= st;
      end
    end
    if (z < 0) z = 0;
    zq = (z + 1024) >>> 11;
    if (zq > 12868) zq = 12868;
    a = x < 0 ? 25736 - zq : zq;
    return wrap_pi(y < 0 ? -a : a);
  endfunction

  function automatic bit solve_arm(longint ex, longint ey, longint c, longint r, bit pick_max,
                                   output longint motor, output longint joint);
    longint q, f1, f2, m, k, s, beta, alpha, psi, cm, cp;
    longint unsigned u1, u2;
    bit use_p;
    motor = 0;
    joint = 0;
    q = ex * ex + ey * ey;
    if (q == 0) return 0;
    f1 = 4 * (c + r) * (c + r) - q;
    f2 = q - 4 * (c - r) * (c - r);
    if (f1 < 0 || f2 < 0) return 0;
    m = 4 * c * c - 4 * r * r + q;
    k = 4 * c * c + 4 * r * r - q;
    u1 = f1;
    u2 = f2;
    s = int_sqrt((u1 >> 4) * u2 + (((u1 & 15) * u2) >> 4));
    beta = cordic_atan2(ey, ex);
    alpha = cordic_atan2(s, asr(m, 2));
    psi = cordic_atan2(s, asr(k, 2));
    cm = wrap_pi(beta - alpha);
    cp = wrap_pi(beta + alpha);
    use_p = (f1 != 0 && f2 != 0) && (pick_max ? (cp > cm) : (cp < cm));
    motor = use_p ? cp : cm;
    joint = use_p ? wrap_pi(psi - 25736) : wrap_pi(25736 - psi);
    return 1;
  endfunction

  function automatic angles_t solve_target(logic signed [15:0] x, logic signed [15:0] y);
    angles_t o;
    longint lm, lj, rm, rj;
    bit okl, okr;
    okl = solve_arm(2 * longint'(x) + lens[4], 2 * longint'(y), lens[0], lens[1], 1, lm, lj);
    okr = solve_arm(2 * longint'(x) - lens[4], 2 * longint'(y), lens[3], lens[2], 0, rm, rj);
    o.ok = okl && okr;
    o.lm = o.ok ? lm[15:0] : '0;
    o.lj = o.ok ? lj[15:0] : '0;
    o.rj = o.ok ? rj[15:0] : '0;
    o.rm = o.ok ? rm[15:0] : '0;
    return o;
  endfunction

  task automatic write_len(reg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    lens[idx] = longint'(val & 32'h7fff);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_lengths(int unsigned lc, int unsigned lr, int unsigned rr,
                             int unsigned rc, int unsigned b);
    write_len(REG_LCRANK, lc);
    write_len(REG_LROD, lr);
    write_len(REG_RROD, rr);
    write_len(REG_RCRANK, rc);
    write_len(REG_BASE, b);
  endtask

  task automatic push_target(logic signed [15:0] x, logic signed [15:0] y, bit known,
                             angles_t res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push <= 1'b1;
    target_x_i <= x;
    target_y_i <= y;
    do @(posedge clk_i); while (full);
    angle_q.push_back(known ? res : solve_target(x, y));
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (angle_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic random_targets(int n);
    logic signed [15:0] x, y;
    longint reach;
    for (int i = 0; i < n; i++) begin
      reach = (lens[0] + lens[1] + lens[2] + lens[3]) / 2 + 4;
      if (reach > 32767) reach = 32767;
      if ($urandom_range(0, 4) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(0, 2 * reach) - reach);
        y = 16'($urandom_range(0, 2 * reach) - reach);
      end
      push_target(x, y, 0, '0);
    end
  endtask

  always begin
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      pop <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    pop <= 1'b1;
  end

  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && pop && !empty) begin
      if (angle_q.size() == 0) begin
        $error("result with no pending item");
        errors++;
      end else begin
        e = angle_q.pop_front();
        if (e.ok) n_solved++;
        else n_unreach++;
        if (valid_res_o !== e.ok) begin
          $error("valid_res exp %0d got %0d", e.ok, valid_res_o);
          errors++;
        end
        if (left_motor_angle_o !== e.lm) begin
          $error("left_motor_angle exp %0d got %0d", e.lm, left_motor_angle_o);
          errors++;
        end
        if (left_joint_angle_o !== e.lj) begin
          $error("left_joint_angle exp %0d got %0d", e.lj, left_joint_angle_o);
          errors++;
        end
        if (right_joint_angle_o !== e.rj) begin
          $error("right_joint_angle exp %0d got %0d", e.rj, right_joint_angle_o);
          errors++;
        end
        if (right_motor_angle_o !== e.rm) begin
          $error("right_motor_angle exp %0d got %0d", e.rm, right_motor_angle_o);
          errors++;
        end
      end
    end
  end

  initial begin
    target_row_t rows [$];
    lens = '{3680, 4320, 4320, 3680, 3200};
    rows = '{
      '{16'sh8000, 16'sh8000, 1, '0},
      '{16'sh7fff, 16'sh7fff, 1, '0},
      '{16'sh7fff, 16'sh8000, 1, '0},
      '{16'sh8000, 16'sh7fff, 1, '0},
      '{-16'sd1600, 16'sd0, 1, '0},
      '{16'sd1600, 16'sd0, 1, '0},
      '{16'sd0, 16'sd8000, 0, '0},
      '{16'sd0, -16'sd8000, 0, '0},
      '{16'sd0, 16'sd0, 0, '0},
      '{16'sd0, 16'sd6000, 0, '0},
      '{16'sd2000, 16'sd3000, 0, '0},
      '{-16'sd2000, 16'sd3000, 0, '0},
      '{16'sd0, 16'sd9456, 0, '0},
      '{16'sd0, 16'sd1, 0, '0},
      '{-16'sd1, -16'sd1, 0, '0}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) push_target(rows[i].x, rows[i].y, rows[i].known, rows[i].res);
    drain();
    set_lengths(32767, 32767, 32767, 32767, 32767);
    push_target(16'sh7fff, 16'sh7fff, 0, '0);
    push_target(16'sh8000, 16'sh8000, 0, '0);
    push_target(16'sd0, 16'sd0, 0, '0);
    drain();
    set_lengths(1, 1, 1, 1, 1);
    push_target(16'sd0, 16'sd0, 0, '0);
    push_target(16'sd0, 16'sd1, 0, '0);
    push_target(16'sd1, 16'sd0, 0, '0);
    random_targets(30);
    drain();
    set_lengths(0, 0, 5, 0, 0);
    push_target(16'sd0, 16'sd0, 0, '0);
    push_target(16'sd2, 16'sd1, 0, '0);
    drain();
    set_lengths(3680, 4320, 4320, 3680, 3200);
    random_targets(500);
    drain();
    set_lengths($urandom_range(1, 32767), $urandom_range(1, 32767), $urandom_range(1, 32767),
                $urandom_range(1, 32767), $urandom_range(1, 32767));
    random_targets(200);
    drain();
    set_lengths(1000, 3000, 2500, 1500, 800);
    random_targets(300);
    calm = 1'b1;
    random_targets(150);
    drain();
    $display("Covered %0d solved and %0d unreachable targets over several link settings.",
             n_solved, n_unreach);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
